// ===== hw/rtl/dra_pkg.sv =====
// ============================================================================
// dra_pkg
// Shared types, codes and helpers of the damage rectangle accumulator.
// ============================================================================
package dra_pkg;

    // Item modes.
    typedef enum logic [1:0] {
        MODE_ADD_FULL    = 2'd0,
        MODE_ADD_CONTENT = 2'd1,
        MODE_DRAIN       = 2'd2,
        MODE_UNUSED      = 2'd3
    } t_mode;

    // Configuration register map.
    localparam int unsigned CFG_AW = 3;
    localparam logic REG_SCREEN_W = 1'b0;
    localparam logic REG_SCREEN_H = 1'b1;

    localparam logic [12:0] SCREEN_MAX = 13'd4096;
    localparam logic [12:0] SCREEN_W_RST = 13'd1024;
    localparam logic [12:0] SCREEN_H_RST = 13'd768;

    typedef struct packed {
        t_mode              mode;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
    } t_in_item;

    typedef struct packed {
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [12:0] out_w;
        logic [12:0] out_h;
        logic        inner_only;
        logic        last;
    } t_out_item;

    // One stored list entry (51 bits).
    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [12:0] w;
        logic [12:0] h;
        logic        co;
    } t_entry;

    typedef struct packed {
        logic   keep;
        t_entry entry;
    } t_clip_res;

    // Screen sizes outside 1..4096 are pinned to the nearest bound.
    function automatic logic [12:0] clamp_size(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > SCREEN_MAX) begin
            r = SCREEN_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/dra_clip.sv =====
// ============================================================================
// dra_clip
// Clips an incoming rectangle to the screen and decides whether it is kept.
// ============================================================================
module dra_clip (
    input  dra_pkg::t_in_item  i_item,
    input  logic [12:0]        i_screen_w,
    input  logic [12:0]        i_screen_h,
    output dra_pkg::t_clip_res o_res
);

    logic signed [16:0] x0, y0, x1, y1, x1c, y1c, sw, sh, dw, dh;
    logic               size_ok;

    always_comb begin
        sw  = $signed({4'b0, i_screen_w});
        sh  = $signed({4'b0, i_screen_h});
        x0  = i_item.rect_x[15] ? 17'sd0 : $signed({1'b0, i_item.rect_x});
        y0  = i_item.rect_y[15] ? 17'sd0 : $signed({1'b0, i_item.rect_y});
        x1  = $signed({i_item.rect_x[15], i_item.rect_x})
            + $signed({i_item.rect_w[15], i_item.rect_w});
        y1  = $signed({i_item.rect_y[15], i_item.rect_y})
            + $signed({i_item.rect_h[15], i_item.rect_h});
        x1c = (x1 > sw) ? sw : x1;
        y1c = (y1 > sh) ? sh : y1;
        dw  = x1c - x0;
        dh  = y1c - y0;
        // Width and height must both be strictly positive.
        size_ok = !i_item.rect_w[15] && (i_item.rect_w != 16'sd0)
               && !i_item.rect_h[15] && (i_item.rect_h != 16'sd0);

        o_res.keep     = size_ok && (x1c > x0) && (y1c > y0);
        o_res.entry.x  = x0[11:0];
        o_res.entry.y  = y0[11:0];
        o_res.entry.w  = dw[12:0];
        o_res.entry.h  = dh[12:0];
        o_res.entry.co = (i_item.mode == dra_pkg::MODE_ADD_CONTENT);
    end

endmodule

// ===== hw/rtl/dra_store.sv =====
// ============================================================================
// dra_store
// Entry memory: one write port, one read port with registered read data.
// ============================================================================
module dra_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  dra_pkg::t_entry  i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output dra_pkg::t_entry  o_rdata
);

    dra_pkg::t_entry mem [DEPTH];
    dra_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/damage_rect_accumulator_core.sv =====
// ============================================================================
// damage_rect_accumulator_core
// Collects clipped screen damage rectangles and drains them on request.
// ============================================================================
// An item is taken when start is high and busy is low. An add item (mode 0
// or 1) is clipped and registered in the cycle it is taken, and the entry is
// written to the list memory in the next one. Adds never produce results. A
// drain item with the full-screen flag set produces one full-screen result in
// the cycle after it is taken. Otherwise a drain of N stored entries keeps busy
// high while the read counter walks the list memory; the first result passes
// the state register and the registered read data, and the rest follow in every
// cycle, the final one marked with last. Results are shown for exactly one
// cycle under o_strobe and the receiver cannot hold them off, so nothing is
// ever lost downstream. The block is ready again in the cycle that carries
// the final result. Screen size registers are to be written through the APB
// port while the block is idle; the block itself does not enforce this. They
// hold raw 13-bit values and are pinned to the range 1..4096 where they are
// used.
module damage_rect_accumulator_core #(
    parameter int unsigned LIST_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Command channel.
    input  logic                         start,
    output logic                         busy,
    input  dra_pkg::t_in_item            i_item,
    // Result channel.
    output logic                         o_strobe,
    output dra_pkg::t_out_item           o_result,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dra_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ADD   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [12:0]      r_screen_w, r_screen_h;
    logic [12:0]      sw_eff, sh_eff;
    logic [CW-1:0]    r_count, n_count;
    logic             r_full, n_full;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_rd_vld, n_rd_vld;
    logic             r_rd_last, n_rd_last;
    logic             r_fs_vld, n_fs_vld;
    logic [12:0]      r_fs_w, r_fs_h;
    dra_pkg::t_clip_res r_add;
    dra_pkg::t_clip_res clip_res;
    dra_pkg::t_entry  rd_data;
    logic             accept, mem_we, mem_re, rd_is_last;
    logic             cfg_wr;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= dra_pkg::SCREEN_W_RST;
            r_screen_h <= dra_pkg::SCREEN_H_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                dra_pkg::REG_SCREEN_W: r_screen_w <= pwdata[12:0];
                dra_pkg::REG_SCREEN_H: r_screen_h <= pwdata[12:0];
                default:               r_screen_w <= r_screen_w;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            dra_pkg::REG_SCREEN_W: prdata = {19'b0, r_screen_w};
            dra_pkg::REG_SCREEN_H: prdata = {19'b0, r_screen_h};
            default:               prdata = 32'b0;
        endcase
    end

    assign sw_eff = dra_pkg::clamp_size(r_screen_w);
    assign sh_eff = dra_pkg::clamp_size(r_screen_h);

    // ------------------------------------------------------------------
    // Clipping of the incoming rectangle.
    // ------------------------------------------------------------------
    dra_clip u_clip (
        .i_item     (i_item),
        .i_screen_w (sw_eff),
        .i_screen_h (sh_eff),
        .o_res      (clip_res)
    );

    // ------------------------------------------------------------------
    // Control sequencer.
    // ------------------------------------------------------------------
    assign busy   = !r_state[0];
    assign accept = start && !busy;

    // The read counter stops on the entry whose index is one below the stored count.
    assign rd_is_last = ({1'b0, r_rd_idx} + {{CW{1'b0}}, 1'b1}) == {1'b0, r_count};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_full    = r_full;
        n_rd_idx  = r_rd_idx;
        n_rd_vld  = 1'b0;
        n_rd_last = 1'b0;
        n_fs_vld  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.mode)
                        dra_pkg::MODE_ADD_FULL,
                        dra_pkg::MODE_ADD_CONTENT: begin
                            n_state = S_ADD;
                        end
                        dra_pkg::MODE_DRAIN: begin
                            // The flag is cleared at once; the count is cleared at once with a full-screen
                            // result, else when the last entry has been read.
                            n_full = 1'b0;
                            if (r_full) begin
                                n_fs_vld = 1'b1;
                                n_count  = '0;
                            end else if (r_count != '0) begin
                                n_state  = S_DRAIN;
                                n_rd_idx = '0;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD: begin
                n_state = S_IDLE;
                if (r_add.keep && !r_full) begin
                    if (r_count >= CW'(LIST_DEPTH)) begin
                        n_full = 1'b1;
                    end else begin
                        mem_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
            end
            S_DRAIN: begin
                mem_re    = 1'b1;
                n_rd_vld  = 1'b1;
                n_rd_last = rd_is_last;
                n_rd_idx  = r_rd_idx + CW'(1);
                if (rd_is_last) begin
                    n_state = S_IDLE;
                    n_count = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_full    <= 1'b1;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_fs_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_full    <= n_full;
            r_rd_idx  <= n_rd_idx;
            r_rd_vld  <= n_rd_vld;
            r_rd_last <= n_rd_last;
            r_fs_vld  <= n_fs_vld;
        end
    end

    // Payload registers: the clipped add and the full-screen size.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_add  <= clip_res;
            r_fs_w <= sw_eff;
            r_fs_h <= sh_eff;
        end
    end

    // ------------------------------------------------------------------
    // Entry memory. Writes only happen in S_ADD and reads only in S_DRAIN,
    // so the two ports never touch the same entry in one cycle.
    // ------------------------------------------------------------------
    dra_store #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_add.entry),
        .i_re    (mem_re),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // ------------------------------------------------------------------
    // Result output: either the full-screen rectangle or the entry just
    // read from memory. The two sources never collide.
    // ------------------------------------------------------------------
    assign o_strobe = r_fs_vld || r_rd_vld;

    always_comb begin
        if (r_fs_vld) begin
            o_result.out_x      = 12'd0;
            o_result.out_y      = 12'd0;
            o_result.out_w      = r_fs_w;
            o_result.out_h      = r_fs_h;
            o_result.inner_only = 1'b0;
            o_result.last       = 1'b1;
        end else begin
            o_result.out_x      = rd_data.x;
            o_result.out_y      = rd_data.y;
            o_result.out_w      = rd_data.w;
            o_result.out_h      = rd_data.h;
            o_result.inner_only = rd_data.co;
            o_result.last       = r_rd_last;
        end
    end

endmodule

// ===== hw/rtl/dra_checker.sv =====
// ============================================================================
// dra_checker
// Port-level checks of the damage rectangle accumulator, bound to the core.
// ============================================================================
module dra_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input dra_pkg::t_in_item  i_item,
    input logic               o_strobe,
    input dra_pkg::t_out_item o_result
);

    logic take_add;

    assign take_add = start && !busy
                   && ((i_item.mode == dra_pkg::MODE_ADD_FULL)
                    || (i_item.mode == dra_pkg::MODE_ADD_CONTENT));

    // Reset leaves the block idle with no result pending.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("result or busy right after reset");

    // An add occupies the next cycle and never produces a result.
    a_add_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_add |=> (busy && !o_strobe))
        else $error("add not held busy or produced a result");

    // Drain results come in an unbroken burst up to the one marked last.
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("drain burst broken before last");

    // Nothing follows the last result of a drain directly.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> !o_strobe)
        else $error("result right after last");

    // Every result is a non-empty rectangle.
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_result.out_w != 13'd0) && (o_result.out_h != 13'd0)))
        else $error("empty rectangle emitted");

endmodule

bind damage_rect_accumulator_core dra_checker u_dra_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== tb/damage_rect_accumulator_core_tb.sv =====
// ============================================================================
// damage_rect_accumulator_core_tb
// Self-checking bench for the damage rectangle accumulator. A negedge driver
// feeds add and drain commands from a backlog, a posedge monitor mirrors the
// list and the full-screen flag in a behavioral copy, and every strobed
// rectangle is compared field by field with the oldest one that is due.
// ============================================================================
module damage_rect_accumulator_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIST_DEPTH  = 64;
    localparam int          CYCLE_LIMIT = 200000;
    // Cycles allowed for an add to reach the list memory before a register
    // write, and for stray results to show up at the very end.
    localparam int          SETTLE      = 8;
    localparam int          PHASES      = 5;

    // ------------------------------------------------------------------------
    // Clock, reset and block signals. Every input has a known value from the
    // first time step on.
    // ------------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    dra_pkg::t_in_item  i_item = '0;
    logic        o_strobe;
    dra_pkg::t_out_item o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [dra_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    damage_rect_accumulator_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Behavioral copy of the accumulator: raw register values, the stored
    // list, its fill level and the full-screen flag, all at reset values.
    // ------------------------------------------------------------------------
    logic [12:0] scr_w_reg    = dra_pkg::SCREEN_W_RST;
    logic [12:0] scr_h_reg    = dra_pkg::SCREEN_H_RST;
    dra_pkg::t_entry dmg_list[LIST_DEPTH];
    int unsigned dmg_count    = 0;
    logic        whole_screen = 1'b1;

    // Rectangles that the accepted drains still owe, oldest first.
    dra_pkg::t_out_item due_rects[$];
    // Commands waiting for the driver.
    dra_pkg::t_in_item  pending_cmds[$];

    int          items_sent   = 0;
    int          items_taken  = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;
    logic        took_item    = 1'b0;
    // While set, the driver never pauses between items.
    logic        steady       = 1'b0;

    // Screen sizes outside 1..4096 are used as the nearest bound.
    function automatic int pinned(input logic [12:0] raw);
        int v;
        v = int'(raw);
        if (v < 1) begin
            v = 1;
        end else if (v > 4096) begin
            v = 4096;
        end
        return v;
    endfunction

    // Applies one accepted item to the copy and queues the rectangles that
    // it makes the block emit.
    task automatic track_damage(input dra_pkg::t_in_item it);
        int                 sw, sh, x, y, w, h, x0, y0, x1, y1;
        dra_pkg::t_out_item r;
        dra_pkg::t_entry    e;
        sw = pinned(scr_w_reg);
        sh = pinned(scr_h_reg);
        unique case (it.mode)
            dra_pkg::MODE_DRAIN: begin
                if (whole_screen) begin
                    // The whole screen in one rectangle, never content-only.
                    r = '0;
                    r.out_w = 13'(sw);
                    r.out_h = 13'(sh);
                    r.last = 1'b1;
                    due_rects.push_back(r);
                end else begin
                    for (int i = 0; i < int'(dmg_count); i++) begin
                        e = dmg_list[i];
                        r.out_x = e.x;
                        r.out_y = e.y;
                        r.out_w = e.w;
                        r.out_h = e.h;
                        r.inner_only = e.co;
                        r.last = (i + 1 == int'(dmg_count));
                        due_rects.push_back(r);
                    end
                end
                dmg_count = 0;
                whole_screen = 1'b0;
            end
            dra_pkg::MODE_ADD_FULL, dra_pkg::MODE_ADD_CONTENT: begin
                x = $signed(it.rect_x);
                y = $signed(it.rect_y);
                w = $signed(it.rect_w);
                h = $signed(it.rect_h);
                if (w > 0 && h > 0) begin
                    x0 = (x < 0) ? 0 : x;
                    y0 = (y < 0) ? 0 : y;
                    x1 = (x + w > sw) ? sw : x + w;
                    y1 = (y + h > sh) ? sh : y + h;
                    // Nothing left after clipping, or the flag already covers it.
                    if (x1 > x0 && y1 > y0 && !whole_screen) begin
                        if (dmg_count >= LIST_DEPTH) begin
                            whole_screen = 1'b1;
                        end else begin
                            e.x = 12'(x0);
                            e.y = 12'(y0);
                            e.w = 13'(x1 - x0);
                            e.h = 13'(y1 - y0);
                            e.co = (it.mode == dra_pkg::MODE_ADD_CONTENT);
                            dmg_list[dmg_count] = e;
                            dmg_count++;
                        end
                    end
                end
            end
            default: begin
                // The unused mode is ignored outright.
            end
        endcase
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. Inputs move at the falling edge. An item stays on the port with
    // start high until the monitor has seen it taken; start is assigned once
    // per edge so a back-to-back item never shows a dip.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive
        logic idle;
        idle = !steady && ($urandom_range(0, 99) < 10);
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took_item) begin
            if (pending_cmds.size() != 0 && !idle) begin
                i_item <= pending_cmds.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Samples at the rising edge: an item counts as taken when start
    // is high and busy is low, and each strobed rectangle is checked against
    // the oldest one due. The cycle counter doubles as the watchdog.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        dra_pkg::t_out_item want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: no progress, %0d rectangles still due", $time, due_rects.size());
            $display("simulation failed");
            $finish;
        end else begin
            took_item <= i_rst_n && start && !busy;
            if (i_rst_n && start && !busy) begin
                track_damage(i_item);
                items_taken++;
            end
            if (i_rst_n && o_strobe) begin
                if (due_rects.size() == 0) begin
                    $display("%0t: rectangle with none expected, actual x=%0d y=%0d w=%0d h=%0d",
                             $time, o_result.out_x, o_result.out_y,
                             o_result.out_w, o_result.out_h);
                    mismatches++;
                end else begin
                    want = due_rects.pop_front();
                    report_field("out_x", want.out_x, o_result.out_x);
                    report_field("out_y", want.out_y, o_result.out_y);
                    report_field("out_w", want.out_w, o_result.out_w);
                    report_field("out_h", want.out_h, o_result.out_h);
                    report_field("inner_only", want.inner_only, o_result.inner_only);
                    report_field("last", want.last, o_result.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command builders.
    // ------------------------------------------------------------------------
    function automatic dra_pkg::t_in_item rect_cmd(input dra_pkg::t_mode m,
                                                   input int x, input int y,
                                                   input int w, input int h);
        dra_pkg::t_in_item it;
        it.mode = m;
        it.rect_x = 16'(x);
        it.rect_y = 16'(y);
        it.rect_w = 16'(w);
        it.rect_h = 16'(h);
        return it;
    endfunction

    // A drain ignores the rectangle fields, so they carry random bits.
    function automatic dra_pkg::t_in_item drain_cmd();
        return rect_cmd(dra_pkg::MODE_DRAIN, $urandom(), $urandom(), $urandom(), $urandom());
    endfunction

    // A rectangle that starts on screen and therefore always survives clipping.
    function automatic dra_pkg::t_in_item inner_add(input int cw, input int ch);
        return rect_cmd($urandom_range(0, 1) ? dra_pkg::MODE_ADD_CONTENT
                                             : dra_pkg::MODE_ADD_FULL,
                        $urandom_range(0, cw - 1), $urandom_range(0, ch - 1),
                        $urandom_range(1, cw), $urandom_range(1, ch));
    endfunction

    // Mostly rectangles around the screen edges, some of them clipped or lost;
    // the rest are raw bit patterns in any mode.
    function automatic dra_pkg::t_in_item random_add(input int cw, input int ch);
        if ($urandom_range(0, 99) < 15) begin
            return rect_cmd(dra_pkg::t_mode'($urandom_range(0, 3)),
                            $urandom(), $urandom(), $urandom(), $urandom());
        end
        return rect_cmd($urandom_range(0, 1) ? dra_pkg::MODE_ADD_CONTENT
                                             : dra_pkg::MODE_ADD_FULL,
                        int'($urandom_range(0, cw + 15)) - 8,
                        int'($urandom_range(0, ch + 15)) - 8,
                        $urandom_range(1, cw / 2 + 8), $urandom_range(1, ch / 2 + 8));
    endfunction

    task automatic queue_cmd(input dra_pkg::t_in_item it);
        pending_cmds.push_back(it);
        items_sent++;
    endtask

    // Waits until every item is taken and every due rectangle has come, then
    // leaves room for a trailing add to land in the list.
    task automatic drain_out();
        wait (items_taken == items_sent);
        wait (due_rects.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Two-phase register write; the register takes the value at the edge that
    // ends the access cycle.
    task automatic cfg_write(input logic idx, input logic [12:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {19'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx == dra_pkg::REG_SCREEN_W) begin
            scr_w_reg = value;
        end else begin
            scr_h_reg = value;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    logic [12:0] phase_w[PHASES] = '{13'd1920, 13'd0, 13'd4096, 13'd64, 13'd5000};
    logic [12:0] phase_h[PHASES] = '{13'd1080, 13'd8191, 13'd4096, 13'd48, 13'd0};

    initial begin
        int cw, ch, made, burst, long_len;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset screen size of 1024 x 768. The flag is
        // set out of reset, so the first add is swallowed and the first drain
        // reports the whole screen.
        queue_cmd(rect_cmd(dra_pkg::MODE_ADD_FULL, 10, 10, 5, 5));
        queue_cmd(drain_cmd());
        // Empty list with the flag clear: no rectangle at all.
        queue_cmd(drain_cmd());
        queue_cmd(rect_cmd(dra_pkg::MODE_UNUSED, -1, -1, -1, -1));
        // Degenerate sizes are dropped before clipping.
        queue_cmd(rect_cmd(dra_pkg::MODE_ADD_FULL, 5, 5, 0, 5));
        queue_cmd(rect_cmd(dra_pkg::MODE_ADD_CONTENT, 5, 5, 5, -32768));
        // Wholly off screen in each direction.
        queue_cmd(rect_cmd(dra_pkg::MODE_ADD_FULL, -32768, -32768, 32767, 32767));
        queue_cmd(rect_cmd(dra_pkg::MODE_ADD_FULL, 32767, 0, 1, 1));
        queue_cmd(rect_cmd(dra_pkg::MODE_ADD_CONTENT, 1024, 0, 10, 10));
        queue_cmd(rect_cmd(dra_pkg::MODE_ADD_FULL, 0, 768, 10, 10));
        // Clipped on the near and far sides, the last pixel, the full screen.
        queue_cmd(rect_cmd(dra_pkg::MODE_ADD_FULL, -5, -5, 10, 10));
        queue_cmd(rect_cmd(dra_pkg::MODE_ADD_CONTENT, 1000, 700, 32767, 32767));
        queue_cmd(rect_cmd(dra_pkg::MODE_ADD_CONTENT, 1023, 767, 1, 1));
        queue_cmd(rect_cmd(dra_pkg::MODE_ADD_FULL, 0, 0, 32767, 32767));
        queue_cmd(drain_cmd());
        // A single entry drain carries last on its only rectangle.
        queue_cmd(rect_cmd(dra_pkg::MODE_ADD_CONTENT, -1, 20, 3, 4));
        queue_cmd(drain_cmd());
        queue_cmd(drain_cmd());
        drain_out();

        // Random part, one screen setting per phase. Phase 1 fills the list
        // exactly and runs without any gaps from the sender, and phase 3
        // overflows the list by one so the flag comes back.
        for (int p = 0; p < PHASES; p++) begin
            cfg_write(dra_pkg::REG_SCREEN_W, phase_w[p]);
            cfg_write(dra_pkg::REG_SCREEN_H, phase_h[p]);
            cw = pinned(phase_w[p]);
            ch = pinned(phase_h[p]);
            steady = (p == 1);
            long_len = (p == 1) ? LIST_DEPTH : (p == 3) ? LIST_DEPTH + 1 : 0;
            for (int i = 0; i < long_len; i++) begin
                queue_cmd(inner_add(cw, ch));
            end
            if (long_len != 0) begin
                queue_cmd(drain_cmd());
            end
            made = 0;
            while (made < 3) begin
                burst = $urandom_range(0, 6);
                repeat (burst) queue_cmd(random_add(cw, ch));
                queue_cmd(drain_cmd());
                made += burst + 1;
                if ($urandom_range(0, 5) == 0) begin
                    queue_cmd(drain_cmd());
                    made++;
                end
            end
            drain_out();
        end

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
